FILE: design/assert_macros.svh
// Assertion macros shared by the midpoint filter RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mpf_pkg.sv
// Shared constants, types and register codes of the 3x3 midpoint filter.
// No dependencies.
package mpf_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIXEL_BITS = 8;

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
	localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);
	localparam int OROW_BITS = $clog2(MAX_HEIGHT);
	// input row runs up to two rows past the frame while draining
	localparam int IROW_BITS = $clog2(MAX_HEIGHT + 2);

	localparam int FW_BITS = 11;
	localparam int FH_BITS = 13;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_IDX_BITS = 1;
	localparam logic [FW_BITS-1:0] FW_RESET = 11'd98;
	localparam logic [FH_BITS-1:0] FH_RESET = 13'd96;

	// power of two so the pointers wrap by themselves
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	// index 0 is the top row of a window column
	typedef logic [2:0][PIXEL_BITS-1:0] column_t;

	localparam pixel_t PIX_MAX = '1;
	localparam pixel_t PIX_MIN = '0;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// which window rows and columns lie inside the frame
	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} mask_t;

	typedef struct packed {
		logic  emit;
		logic  last;
		mask_t mask;
	} res_ctl_t;

	typedef struct packed {
		logic                shift;
		res_ctl_t            res;
		logic [COL_BITS-1:0] addr;
		pixel_t              fresh;
	} issue_t;

	typedef struct packed {
		pixel_t upper;
		pixel_t middle;
	} line_pair_t;

	typedef struct packed {
		pixel_t value;
		logic   last;
	} result_t;

endpackage

FILE: design/mpf_pixel_if.sv
// Input channel of the midpoint filter: one pixel or flush per transfer.
// Depends on mpf_pkg.
interface mpf_pixel_if;
	logic            valid;
	logic            ready;
	mpf_pkg::pixel_t pixel_value;
	logic            flush;

	modport source(output valid, pixel_value, flush, input ready);
	modport sink(input valid, pixel_value, flush, output ready);
endinterface

FILE: design/mpf_result_if.sv
// Output channel of the midpoint filter: one filtered pixel per transfer.
// Depends on mpf_pkg.
interface mpf_result_if;
	logic            valid;
	logic            ready;
	mpf_pkg::pixel_t filtered_value;
	logic            last_of_frame;

	modport source(output valid, filtered_value, last_of_frame, input ready);
	modport sink(input valid, filtered_value, last_of_frame, output ready);
endinterface

FILE: design/mpf_line_store.sv
// Paired line stores (upper and middle row), one word per column.
// Registered read with a one-deep forward of the write in flight. Depends on mpf_pkg.
module mpf_line_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [mpf_pkg::COL_BITS-1:0] rd_addr,
	input  logic                         wr_en,
	input  logic [mpf_pkg::COL_BITS-1:0] wr_addr,
	input  mpf_pkg::line_pair_t          wr_data,
	output mpf_pkg::line_pair_t          rd_data
);

	mpf_pkg::line_pair_t mem [mpf_pkg::MAX_WIDTH];
	mpf_pkg::line_pair_t rd_q;
	mpf_pkg::line_pair_t byp_data_q;
	logic                byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// a one-column frame reads the column that is being written back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

FILE: design/mpf_cell.sv
// One column of the 3x3 window: holds three pixels, passes them on at each shift
// and reduces them to a masked minimum and maximum. Depends on mpf_pkg.
module mpf_cell (
	input  logic              clk,
	input  logic              shift_en,
	input  mpf_pkg::column_t  col_in,
	input  logic              col_ok,
	input  logic              top_ok,
	input  logic              bot_ok,
	output mpf_pkg::column_t  col_out,
	output mpf_pkg::pixel_t   col_min,
	output mpf_pkg::pixel_t   col_max
);

	mpf_pkg::column_t pix_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			pix_q <= col_in;
		end
	end

	assign col_out = pix_q;

	always_comb begin
		mpf_pkg::pixel_t lo;
		mpf_pkg::pixel_t hi;
		lo = pix_q[1];
		hi = pix_q[1];
		if (top_ok) begin
			if (pix_q[0] < lo) lo = pix_q[0];
			if (pix_q[0] > hi) hi = pix_q[0];
		end
		if (bot_ok) begin
			if (pix_q[2] < lo) lo = pix_q[2];
			if (pix_q[2] > hi) hi = pix_q[2];
		end
		// a column outside the frame is neutral for both reductions
		if (!col_ok) begin
			lo = mpf_pkg::PIX_MAX;
			hi = mpf_pkg::PIX_MIN;
		end
		col_min = lo;
		col_max = hi;
	end

endmodule

FILE: design/mpf_ctrl.sv
// Frame registers and raster sequencer: input and output position counters,
// the drain after the last pixel and the per-shift issue word. Depends on mpf_pkg.
`include "assert_macros.svh"

module mpf_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mpf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [mpf_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                              in_valid,
	input  mpf_pkg::pixel_t                   in_pixel,
	input  logic                              in_flush,
	input  logic                              room,
	output logic                              in_ready,
	output mpf_pkg::issue_t                   issue
);

	logic [mpf_pkg::FW_BITS-1:0]     fw_q;
	logic [mpf_pkg::FH_BITS-1:0]     fh_q;
	logic [mpf_pkg::COL_BITS-1:0]    in_col_q;
	logic [mpf_pkg::IROW_BITS-1:0]   in_row_q;
	logic [mpf_pkg::COL_BITS-1:0]    out_col_q;
	logic [mpf_pkg::OROW_BITS-1:0]   out_row_q;
	logic                            cont_q;

	logic [mpf_pkg::WIDTH_BITS-1:0]  w_eff;
	logic [mpf_pkg::HEIGHT_BITS-1:0] h_eff;
	logic [mpf_pkg::COL_BITS-1:0]    w_last;
	logic [mpf_pkg::OROW_BITS-1:0]   h_last;
	logic                            in_frame;
	logic                            primed;
	logic                            fire;
	logic                            have_pixel;

	always_comb begin
		if (fw_q == '0) begin
			w_eff = mpf_pkg::WIDTH_BITS'(1);
		end else if (32'(fw_q) > mpf_pkg::MAX_WIDTH) begin
			w_eff = mpf_pkg::WIDTH_BITS'(mpf_pkg::MAX_WIDTH);
		end else begin
			w_eff = mpf_pkg::WIDTH_BITS'(fw_q);
		end
		if (fh_q == '0) begin
			h_eff = mpf_pkg::HEIGHT_BITS'(1);
		end else if (32'(fh_q) > mpf_pkg::MAX_HEIGHT) begin
			h_eff = mpf_pkg::HEIGHT_BITS'(mpf_pkg::MAX_HEIGHT);
		end else begin
			h_eff = mpf_pkg::HEIGHT_BITS'(fh_q);
		end
	end

	assign w_last = mpf_pkg::COL_BITS'(w_eff - mpf_pkg::WIDTH_BITS'(1));
	assign h_last = mpf_pkg::OROW_BITS'(h_eff - mpf_pkg::HEIGHT_BITS'(1));

	assign in_frame = in_row_q < mpf_pkg::IROW_BITS'(h_eff);
	// raster position at or past width + 1: the window is centered on a result
	assign primed = (in_row_q >= mpf_pkg::IROW_BITS'(2))
		|| ((in_row_q == mpf_pkg::IROW_BITS'(1)) && (in_col_q != '0));

	assign in_ready   = room && !cont_q;
	assign fire       = in_valid && in_ready;
	assign have_pixel = fire && !in_flush && in_frame;

	always_comb begin
		issue.shift = (fire && (!in_flush || !in_frame)) || (cont_q && room);
		issue.res.emit = issue.shift && primed;
		issue.res.last = issue.res.emit && (out_row_q == h_last) && (out_col_q == w_last);
		issue.res.mask.top_ok   = out_row_q != '0;
		issue.res.mask.bot_ok   = out_row_q != h_last;
		issue.res.mask.left_ok  = out_col_q != '0;
		issue.res.mask.right_ok = out_col_q != w_last;
		issue.addr  = in_col_q;
		issue.fresh = have_pixel ? in_pixel : mpf_pkg::PIX_MIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= mpf_pkg::FW_RESET;
			fh_q      <= mpf_pkg::FH_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cont_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (mpf_pkg::cfg_reg_t'(cfg_index))
				mpf_pkg::REG_FRAME_WIDTH: begin
					fw_q <= cfg_wdata[mpf_pkg::FW_BITS-1:0];
				end
				mpf_pkg::REG_FRAME_HEIGHT: begin
					fh_q <= cfg_wdata[mpf_pkg::FH_BITS-1:0];
				end
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cont_q    <= 1'b0;
		end else if (issue.shift) begin
			if (issue.res.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				cont_q    <= 1'b0;
			end else begin
				if (in_col_q == w_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + mpf_pkg::IROW_BITS'(1);
				end else begin
					in_col_q <= in_col_q + mpf_pkg::COL_BITS'(1);
				end
				if (issue.res.emit) begin
					if (out_col_q == w_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + mpf_pkg::OROW_BITS'(1);
					end else begin
						out_col_q <= out_col_q + mpf_pkg::COL_BITS'(1);
					end
				end
				// a drain shift that gave no result goes on without a new transfer
				cont_q <= !issue.res.emit && !have_pixel;
			end
		end
	end

	`MPF_ASSERT_IMP(a_drain_past_frame, clk, arst_n, cont_q, !in_frame, "drain inside frame")
	`MPF_ASSERT_NEXT(a_restart_after_last, clk, arst_n, issue.res.last && !cfg_we, in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0, "no restart after last result")

endmodule

FILE: design/midpoint_filter_3x3.sv
// 3x3 midpoint filter for 8-bit grey frames in raster order. Each result is
// floor((min + max) / 2) over the in-frame part of a pixel's 3x3 neighborhood,
// and leaves frame_width + 1 pixels behind the input; after a frame's last pixel,
// one flush transfer drains one result, the last one marked last_of_frame. One
// transfer is taken per clock unless the input stalls; a result passes the issue_s1
// and res_s2 registers before it is written into a four-entry output queue, and
// the input stalls when that queue with the results still in the shift chain would
// be full. In a one-row frame the first draining flush takes two column shifts, and
// the input is also held while the second one is made. The line stores need no
// clearing pass: the block takes pixels straight after reset. Write the frame
// registers only while idle; a write abandons the frame in progress.
`include "assert_macros.svh"

module midpoint_filter_3x3 (
	input  logic                              clk,
	input  logic                              arst_n,
	mpf_pixel_if.sink                         pixels,
	mpf_result_if.source                      results,
	input  logic                              cfg_we,
	input  logic [mpf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [mpf_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

	mpf_pkg::issue_t     issue;
	mpf_pkg::issue_t     issue_s1;
	mpf_pkg::res_ctl_t   res_s2;
	mpf_pkg::line_pair_t rd_pair;
	mpf_pkg::line_pair_t wr_pair;
	mpf_pkg::column_t    col2_in;
	mpf_pkg::column_t    col2_out;
	mpf_pkg::column_t    col1_out;
	mpf_pkg::column_t    col0_out;
	mpf_pkg::pixel_t     min0, min1, min2;
	mpf_pkg::pixel_t     max0, max1, max2;
	mpf_pkg::pixel_t     win_min, win_max;
	logic [mpf_pkg::PIXEL_BITS:0] mid_sum;
	logic                room;

	mpf_pkg::result_t                  fifo_q [mpf_pkg::FIFO_DEPTH];
	logic [mpf_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [mpf_pkg::FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [mpf_pkg::FIFO_CNT_BITS-1:0] fifo_cnt_q;
	logic [mpf_pkg::FIFO_CNT_BITS:0]   occupancy;
	logic                              push;
	logic                              pop;

	mpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (pixels.valid),
		.in_pixel  (pixels.pixel_value),
		.in_flush  (pixels.flush),
		.room      (room),
		.in_ready  (pixels.ready),
		.issue     (issue)
	);

	// s1: line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= '0;
			res_s2   <= '0;
		end else begin
			issue_s1 <= issue;
			res_s2   <= issue_s1.res;
		end
	end

	assign wr_pair.upper  = rd_pair.middle;
	assign wr_pair.middle = issue_s1.fresh;

	mpf_line_store u_lines (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (issue.shift),
		.rd_addr (issue.addr),
		.wr_en   (issue_s1.shift),
		.wr_addr (issue_s1.addr),
		.wr_data (wr_pair),
		.rd_data (rd_pair)
	);

	assign col2_in[0] = rd_pair.upper;
	assign col2_in[1] = rd_pair.middle;
	assign col2_in[2] = issue_s1.fresh;

	// window columns: cell 2 takes the new column, cell 0 holds the oldest
	mpf_cell u_cell2 (
		.clk      (clk),
		.shift_en (issue_s1.shift),
		.col_in   (col2_in),
		.col_ok   (res_s2.mask.right_ok),
		.top_ok   (res_s2.mask.top_ok),
		.bot_ok   (res_s2.mask.bot_ok),
		.col_out  (col2_out),
		.col_min  (min2),
		.col_max  (max2)
	);

	mpf_cell u_cell1 (
		.clk      (clk),
		.shift_en (issue_s1.shift),
		.col_in   (col2_out),
		.col_ok   (1'b1),
		.top_ok   (res_s2.mask.top_ok),
		.bot_ok   (res_s2.mask.bot_ok),
		.col_out  (col1_out),
		.col_min  (min1),
		.col_max  (max1)
	);

	mpf_cell u_cell0 (
		.clk      (clk),
		.shift_en (issue_s1.shift),
		.col_in   (col1_out),
		.col_ok   (res_s2.mask.left_ok),
		.top_ok   (res_s2.mask.top_ok),
		.bot_ok   (res_s2.mask.bot_ok),
		.col_out  (col0_out),
		.col_min  (min0),
		.col_max  (max0)
	);

	always_comb begin
		win_min = min1;
		win_max = max1;
		if (min0 < win_min) win_min = min0;
		if (min2 < win_min) win_min = min2;
		if (max0 > win_max) win_max = max0;
		if (max2 > win_max) win_max = max2;
	end

	assign mid_sum = {1'b0, win_min} + {1'b0, win_max};

	// output queue; results still in the chain hold a slot in advance
	assign push = res_s2.emit;
	assign pop  = results.valid && results.ready;
	assign occupancy = (mpf_pkg::FIFO_CNT_BITS + 1)'(fifo_cnt_q)
		+ (mpf_pkg::FIFO_CNT_BITS + 1)'(issue_s1.res.emit)
		+ (mpf_pkg::FIFO_CNT_BITS + 1)'(res_s2.emit);
	assign room = occupancy < (mpf_pkg::FIFO_CNT_BITS + 1)'(mpf_pkg::FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{value: mid_sum[mpf_pkg::PIXEL_BITS:1], last: res_s2.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mpf_pkg::FIFO_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mpf_pkg::FIFO_PTR_BITS'(1);
			end
			if (push && !pop) begin
				fifo_cnt_q <= fifo_cnt_q + mpf_pkg::FIFO_CNT_BITS'(1);
			end else if (pop && !push) begin
				fifo_cnt_q <= fifo_cnt_q - mpf_pkg::FIFO_CNT_BITS'(1);
			end
		end
	end

	assign results.valid          = fifo_cnt_q != '0;
	assign results.filtered_value = fifo_q[rd_ptr_q].value;
	assign results.last_of_frame  = fifo_q[rd_ptr_q].last;

	`MPF_ASSERT_IMP(a_fifo_no_overflow, clk, arst_n, push && !pop, fifo_cnt_q != mpf_pkg::FIFO_CNT_BITS'(mpf_pkg::FIFO_DEPTH), "output queue overflow")
	`MPF_ASSERT_NEXT(a_emit_reaches_queue, clk, arst_n, issue.res.emit, issue_s1.res.emit && issue_s1.shift, "result lost in chain")

endmodule
